FILE: rtl/skts_pkg.sv
`default_nettype none

package skts_pkg;

    // Payload field widths
    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 32;
    localparam int POS_W    = 3;
    localparam int STATUS_W = 2;

    // Default table geometry
    localparam int DEPTH_DEF    = 8;
    localparam int KEY_BITS_DEF = 32;

    typedef logic [FUNC_W-1:0]          t_func;
    typedef logic signed [KEY_W-1:0]    t_key;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [STATUS_W-1:0]        t_status;

    // Request codes
    localparam t_func FUNC_LOAD    = 3'd0;
    localparam t_func FUNC_SORT    = 3'd1;
    localparam t_func FUNC_LSEARCH = 3'd2;
    localparam t_func FUNC_BSEARCH = 3'd3;
    localparam t_func FUNC_CLEAR   = 3'd4;

    // Result status codes
    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_FULL  = 2'd1;
    localparam t_status STATUS_EMPTY = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/skts_if.sv
`default_nettype none

// Request channel: one table operation per transfer
interface skts_req_if;
    logic                valid;
    logic                ready;
    skts_pkg::t_func     func;
    skts_pkg::t_key      key;

    modport source (output valid, output func, output key, input ready);
    modport sink   (input valid, input func, input key, output ready);
endinterface

// Result channel: one result per request
interface skts_rsp_if;
    logic                valid;
    logic                ready;
    logic                found;
    skts_pkg::t_pos      position;
    skts_pkg::t_status   status;

    modport source (output valid, output found, output position, output status, input ready);
    modport sink   (input valid, input found, input position, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/skts_key_ram.sv
`default_nettype none

// Key storage: one write port, one read port with registered read data
module skts_key_ram #(
    parameter int DEPTH    = skts_pkg::DEPTH_DEF,
    parameter int KEY_BITS = skts_pkg::KEY_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic signed [KEY_BITS-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic signed [KEY_BITS-1:0] o_rdata
);

    logic signed [KEY_BITS-1:0] r_mem [DEPTH];
    logic signed [KEY_BITS-1:0] r_rdata;

    // Write the addressed entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read every cycle, data valid in the next cycle
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/sorted_key_table_search.sv
// Sorted key table with linear and binary search.
// i_req carries one request per transfer: func selects load, sort, linear
// search, binary search or clear, and key is the key to store or look for.
// o_rsp returns exactly one result per request: found, position, status.
// Keys live in a single-port-read key memory with registered read data.
// Load, clear, an unknown code and an empty table finish without a memory read.
// Linear search examines k entries in order, k from 1 to count.
// Binary search makes p probes, at most log2(count) + 1.
// Sort runs passes j = 0 .. count-2, each a scan of entries j to count-1
// followed by a swap written in two halves (ST_WA, then ST_WB).
// The read port of the key memory allows one compare per read.
// One request is in work at a time; a new request is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, a finished result waits inside until the output
// register frees up. Reset empties the table (count zero) and drops any
// pending result; memory contents are not cleared and need no clearing pass.
`default_nettype none

module sorted_key_table_search #(
    parameter int DEPTH    = skts_pkg::DEPTH_DEF,
    parameter int KEY_BITS = skts_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    skts_req_if.sink   i_req,
    skts_rsp_if.source o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = skts_pkg::POS_W;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_LIN  = 3'd1;
    localparam logic [ST_W-1:0] ST_BIN  = 3'd2;
    localparam logic [ST_W-1:0] ST_SCAN = 3'd3;
    localparam logic [ST_W-1:0] ST_WA   = 3'd4;
    localparam logic [ST_W-1:0] ST_WB   = 3'd5;
    localparam logic [ST_W-1:0] ST_DONE = 3'd6;

    // Control state
    logic [ST_W-1:0]  r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid, n_out_valid;

    // Working registers
    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic signed [KEY_BITS-1:0] r_min, n_min;
    logic signed [KEY_BITS-1:0] r_first, n_first;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [IDX_W-1:0]           r_j, n_j;
    logic [IDX_W-1:0]           r_p, n_p;
    logic [CNT_W-1:0]           r_lo, n_lo;
    logic [CNT_W-1:0]           r_hip1, n_hip1;

    // Pending and output result
    logic                  r_res_found, n_res_found;
    skts_pkg::t_pos        r_res_pos, n_res_pos;
    skts_pkg::t_status     r_res_status, n_res_status;
    logic                  r_out_found, n_out_found;
    skts_pkg::t_pos        r_out_pos, n_out_pos;
    skts_pkg::t_status     r_out_status, n_out_status;

    // Memory port
    logic                       w_we;
    logic [IDX_W-1:0]           w_waddr;
    logic signed [KEY_BITS-1:0] w_wdata;
    logic [IDX_W-1:0]           w_raddr;
    logic signed [KEY_BITS-1:0] w_rdata;

    logic                       w_accept;
    logic                       w_can_emit;
    logic signed [KEY_BITS-1:0] w_key;
    logic                       w_full;
    logic                       w_empty;
    logic                       w_idx_last;
    logic                       w_bin_lt;
    logic                       w_bin_gt;
    logic [CNT_W-1:0]           w_lo_nx;
    logic [CNT_W-1:0]           w_hip1_nx;
    logic [CNT_W-1:0]           w_mid_lo;
    logic [CNT_W-1:0]           w_mid_hi;
    logic [CNT_W:0]             w_mid_sum;
    logic [IDX_W-1:0]           w_mid;

    skts_key_ram #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Handshake and shared decode
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && (r_state == ST_IDLE);
    assign w_can_emit  = !r_out_valid || o_rsp.ready;
    assign w_key       = KEY_BITS'(i_req.key);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_idx_last  = (CNT_W'(r_idx) == (r_count - CNT_W'(1)));

    // Binary search step: narrow the range, then pick the next midpoint
    assign w_bin_lt  = (r_key < w_rdata);
    assign w_bin_gt  = (r_key > w_rdata);
    assign w_lo_nx   = w_bin_lt ? r_lo : (CNT_W'(r_idx) + CNT_W'(1));
    assign w_hip1_nx = w_bin_lt ? CNT_W'(r_idx) : r_hip1;
    assign w_mid_lo  = (r_state == ST_IDLE) ? '0 : w_lo_nx;
    assign w_mid_hi  = (r_state == ST_IDLE) ? r_count : w_hip1_nx;
    assign w_mid_sum = {1'b0, w_mid_lo} + {1'b0, w_mid_hi} - (CNT_W + 1)'(1);
    assign w_mid     = IDX_W'(w_mid_sum[CNT_W:1]);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_key        = r_key;
        n_min        = r_min;
        n_first      = r_first;
        n_idx        = r_idx;
        n_j          = r_j;
        n_p          = r_p;
        n_lo         = r_lo;
        n_hip1       = r_hip1;
        n_res_found  = r_res_found;
        n_res_pos    = r_res_pos;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_found  = r_out_found;
        n_out_pos    = r_out_pos;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_waddr      = r_p;
        w_wdata      = r_first;
        w_raddr      = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_key        = w_key;
                    n_res_found  = 1'b0;
                    n_res_pos    = '0;
                    n_res_status = skts_pkg::STATUS_OK;
                    n_state      = ST_DONE;
                    case (i_req.func)
                        skts_pkg::FUNC_LOAD: begin
                            if (w_full) begin
                                n_res_status = skts_pkg::STATUS_FULL;
                            end else begin
                                w_we      = 1'b1;
                                w_waddr   = IDX_W'(r_count);
                                w_wdata   = w_key;
                                n_res_pos = POS_W'(r_count);
                                n_count   = r_count + CNT_W'(1);
                            end
                        end
                        skts_pkg::FUNC_SORT: begin
                            if (w_empty) begin
                                n_res_status = skts_pkg::STATUS_EMPTY;
                            end else if (r_count != CNT_W'(1)) begin
                                n_j     = '0;
                                n_idx   = '0;
                                n_state = ST_SCAN;
                            end
                        end
                        skts_pkg::FUNC_LSEARCH: begin
                            if (w_empty) begin
                                n_res_status = skts_pkg::STATUS_EMPTY;
                            end else begin
                                n_idx   = '0;
                                n_state = ST_LIN;
                            end
                        end
                        skts_pkg::FUNC_BSEARCH: begin
                            if (w_empty) begin
                                n_res_status = skts_pkg::STATUS_EMPTY;
                            end else begin
                                n_lo    = '0;
                                n_hip1  = r_count;
                                n_idx   = w_mid;
                                w_raddr = w_mid;
                                n_state = ST_BIN;
                            end
                        end
                        skts_pkg::FUNC_CLEAR: begin
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LIN: begin
                // Compare one entry per cycle, prefetch the next
                w_raddr = r_idx + IDX_W'(1);
                if (r_key == w_rdata) begin
                    n_res_found = 1'b1;
                    n_res_pos   = POS_W'(r_idx);
                    n_state     = ST_DONE;
                end else if (w_idx_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_BIN: begin
                if (!w_bin_lt && !w_bin_gt) begin
                    n_res_found = 1'b1;
                    n_res_pos   = POS_W'(r_idx);
                    n_state     = ST_DONE;
                end else begin
                    n_lo   = w_lo_nx;
                    n_hip1 = w_hip1_nx;
                    if (w_lo_nx < w_hip1_nx) begin
                        n_idx   = w_mid;
                        w_raddr = w_mid;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                // Track the first strictly smallest key of this pass
                w_raddr = r_idx + IDX_W'(1);
                if (r_idx == r_j) begin
                    n_min   = w_rdata;
                    n_first = w_rdata;
                    n_p     = r_idx;
                end else if (w_rdata < r_min) begin
                    n_min = w_rdata;
                    n_p   = r_idx;
                end
                if (w_idx_last) begin
                    n_state = ST_WA;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_WA: begin
                // Swap, first half: old head goes to the minimum's slot
                w_we    = 1'b1;
                w_waddr = r_p;
                w_wdata = r_first;
                n_state = ST_WB;
            end
            ST_WB: begin
                // Swap, second half: minimum goes to the head; start next pass
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_min;
                w_raddr = r_j + IDX_W'(1);
                if ((CNT_W'(r_j) + CNT_W'(2)) < r_count) begin
                    n_j     = r_j + IDX_W'(1);
                    n_idx   = r_j + IDX_W'(1);
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hand the result to the output register once it is free
                if (w_can_emit) begin
                    n_out_valid  = 1'b1;
                    n_out_found  = r_res_found;
                    n_out_pos    = r_res_pos;
                    n_out_status = r_res_status;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_min        <= n_min;
        r_first      <= n_first;
        r_idx        <= n_idx;
        r_j          <= n_j;
        r_p          <= n_p;
        r_lo         <= n_lo;
        r_hip1       <= n_hip1;
        r_res_found  <= n_res_found;
        r_res_pos    <= n_res_pos;
        r_res_status <= n_res_status;
        r_out_found  <= n_out_found;
        r_out_pos    <= n_out_pos;
        r_out_status <= n_out_status;
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.status   = r_out_status;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above table depth");

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req.func == skts_pkg::FUNC_LOAD) && !w_full)
        |=> (r_count == ($past(r_count) + CNT_W'(1))))
        else $error("load did not advance the entry count");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && r_out_valid && !o_rsp.ready) |=> (r_state == ST_DONE))
        else $error("pending result dropped while output stalled");

    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_BIN) |-> (r_lo < r_hip1))
        else $error("binary search probing an empty range");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.found) |-> (o_rsp.status == skts_pkg::STATUS_OK))
        else $error("hit reported with non-ok status");

endmodule

`default_nettype wire
